>>> src/per_link_time_table_search_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the per-link time table search.
// The macros expect clk_i and rst_ni in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef PER_LINK_TIME_TABLE_SEARCH_ASSERT_SVH
`define PER_LINK_TIME_TABLE_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLTTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pltts_pkg.sv
// ---------------------------------------------------------------------------
// pltts_pkg
// Shared types, constants and width helpers of the per-link time table search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pltts_pkg;

  localparam int NUM_LINKS_DEF = 16;
  localparam int MAX_STEPS_DEF = 1024;

  // Field widths of the stream items.
  localparam int CMD_W      = 2;
  localparam int LINK_W     = 4;
  localparam int STEP_W     = 10;
  localparam int ECOUNT_W   = 11;
  localparam int TIME_W     = 32;
  localparam int DIS_W      = 32;
  localparam int CFG_W      = 5;
  localparam int S_TDATA_W  = 128;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 40;
  localparam int M_TUSER_W  = 2;

  // At most this many results per query; the link counter holds the limit itself.
  localparam int RES_CAP = 16;
  localparam int KW      = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd1;

  // Tolerance of about 1e-5: tol = (t * 10737) >> 30.
  localparam int             TOL_MUL_W = 14;
  localparam logic [13:0]    TOL_MUL   = 14'd10737;
  localparam int             TOL_SHIFT = 30;
  localparam int             PROD_W    = TIME_W + TOL_MUL_W;
  localparam int             TOL_W     = PROD_W - TOL_SHIFT;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_CLAMP     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [DIS_W-1:0]  discharge;
    status_e           status;
    logic              last;
  } res_t;

  function automatic int link_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int step_w(input int m);
    return (m > 1) ? $clog2(m) : 1;
  endfunction

  function automatic int count_w(input int m);
    return $clog2(m + 1);
  endfunction

endpackage

`default_nettype wire

>>> src/per_link_time_table_search.sv
// ---------------------------------------------------------------------------
// per_link_time_table_search
// Per-link (time, discharge) tables with a tolerant binary search per query.
// ---------------------------------------------------------------------------
// Usage: every input transaction carries a command in s_axis_tuser_i. A load
// writes one table entry and a count command sets a link's entry count; both
// give no result. A query searches links 0 up to active_links-1, at most
// sixteen, in turn and sends one result transaction per link on the master
// side, with tlast on the last link; with active_links zero it sends none.
// A query first registers the tolerance multiply; then per link it checks for
// an empty link, reads the last entry to clamp a time past it, and otherwise
// probes the memory once per search step, with one more read when no entry
// matches. The probes are bounded by ceil(log2(count+1)). The entry memory
// has a single read port and the search one shared compare unit.
// s_axis_tready_o is low while a query is searched; a new transaction is taken
// while the last result still waits in the output register.
// When the receiver stalls, the search holds at the next finished result.
// Reset clears all entry counts and sets active_links to one; the entry memory
// is not cleared and needs no clearing pass. The configuration port is always
// ready; the user must write it only while the block is idle (not enforced).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "per_link_time_table_search_assert.svh"

module per_link_time_table_search
  import pltts_pkg::*;
#(
  parameter int NUM_LINKS = NUM_LINKS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration: active_links.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // Input stream.
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // link_index[3:0], step_index[13:4], entry_time[45:14],
  // entry_discharge[77:46], entry_count[88:78], query_time[120:89], zeros above.
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // cmd[1:0].
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser_i,
  // Result stream.
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // out_link[3:0], out_discharge[35:4], zeros above.
  output logic      [M_TDATA_W-1:0] m_axis_tdata_o,
  // status[1:0].
  output logic      [M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                      m_axis_tlast_o
);

  localparam int LW  = link_w(NUM_LINKS);
  localparam int SW  = step_w(MAX_STEPS);
  localparam int CW  = count_w(MAX_STEPS);
  localparam int AW  = LW + SW;
  localparam int LIM = (NUM_LINKS < RES_CAP) ? NUM_LINKS : RES_CAP;

  logic [CFG_W-1:0]    active_q;
  logic                in_hs;
  logic [LINK_W-1:0]   in_link;
  logic [STEP_W-1:0]   in_step;
  logic [TIME_W-1:0]   in_etime;
  logic [DIS_W-1:0]    in_edis;
  logic [ECOUNT_W-1:0] in_ecount;
  logic [TIME_W-1:0]   in_qtime;
  logic                link_ok, step_ok;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                cnt_we;
  logic [CW-1:0]       cnt_val;
  logic [KW-1:0]       num;
  logic                core_start;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [TIME_W+DIS_W-1:0] rd_data;
  logic                core_busy;
  logic                core_res_valid;
  logic                core_res_ready;
  res_t                core_res;
  logic                out_load;
  logic                m_valid_q, m_valid_d;
  res_t                out_q;

  assign in_hs     = s_axis_tvalid_i && s_axis_tready_o;
  assign in_link   = s_axis_tdata_i[3:0];
  assign in_step   = s_axis_tdata_i[13:4];
  assign in_etime  = s_axis_tdata_i[45:14];
  assign in_edis   = s_axis_tdata_i[77:46];
  assign in_ecount = s_axis_tdata_i[88:78];
  assign in_qtime  = s_axis_tdata_i[120:89];

  assign link_ok = 32'(in_link) < NUM_LINKS;
  assign step_ok = 32'(in_step) < MAX_STEPS;

  assign mem_we    = in_hs && (s_axis_tuser_i == CMD_LOAD) && link_ok && step_ok;
  assign mem_waddr = {LW'(in_link), SW'(in_step)};

  assign cnt_we  = in_hs && (s_axis_tuser_i == CMD_COUNT) && link_ok;
  assign cnt_val = (32'(in_ecount) > MAX_STEPS) ? CW'(MAX_STEPS) : CW'(in_ecount);

  assign num        = (32'(active_q) > LIM) ? KW'(LIM) : KW'(active_q);
  assign core_start = in_hs && (s_axis_tuser_i == CMD_QUERY) && (num != '0);

  assign s_axis_tready_o = !core_busy;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  pltts_table_mem #(
    .NUM_LINKS (NUM_LINKS),
    .MAX_STEPS (MAX_STEPS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i ({in_edis, in_etime}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pltts_search_core #(
    .NUM_LINKS (NUM_LINKS),
    .MAX_STEPS (MAX_STEPS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (core_start),
    .qtime_i     (in_qtime),
    .num_i       (num),
    .cnt_we_i    (cnt_we),
    .cnt_link_i  (LW'(in_link)),
    .cnt_val_i   (cnt_val),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .busy_o      (core_busy),
    .res_valid_o (core_res_valid),
    .res_o       (core_res),
    .res_ready_i (core_res_ready)
  );

  // Output register: refilled when empty or when its transaction completes.
  assign core_res_ready = !m_valid_q || m_axis_tready_i;
  assign out_load       = core_res_valid && core_res_ready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - LINK_W - DIS_W)'(0), out_q.discharge, out_q.link};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

  `PLTTS_ASSERT_NEXT(a_query_starts_search, core_start, core_busy,
                     "accepted query did not start the search")
  `PLTTS_ASSERT_NEXT(a_last_result_ends_query,
                     out_load && core_res.last, !core_busy,
                     "search still busy after the last result")
  `PLTTS_ASSERT_NEXT(a_empty_gives_zero,
                     out_load && (core_res.status == ST_EMPTY),
                     m_axis_tdata_o[35:4] == 32'd0,
                     "empty link result carries a nonzero discharge")
  `PLTTS_ASSERT_NOW(a_read_link_in_range, rd_en,
                    32'(rd_addr[AW-1:SW]) < NUM_LINKS,
                    "memory read outside the configured links")

endmodule

`default_nettype wire

>>> src/pltts_table_mem.sv
// ---------------------------------------------------------------------------
// pltts_table_mem
// Entry memory: one word of {discharge, time} per link and step, one write
// port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pltts_table_mem
  import pltts_pkg::*;
#(
  parameter int NUM_LINKS = NUM_LINKS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  localparam int AW = link_w(NUM_LINKS) + step_w(MAX_STEPS),
  localparam int DW = TIME_W + DIS_W
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/pltts_search_core.sv
// ---------------------------------------------------------------------------
// pltts_search_core
// Sequencer that runs the per-link binary search with one shared compare
// unit, and holds the entry count of every link.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pltts_search_core
  import pltts_pkg::*;
#(
  parameter int NUM_LINKS = NUM_LINKS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  localparam int LW = link_w(NUM_LINKS),
  localparam int SW = step_w(MAX_STEPS),
  localparam int CW = count_w(MAX_STEPS),
  localparam int AW = LW + SW
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Query start and count writes, only while idle.
  input  wire logic                     start_i,
  input  wire logic [TIME_W-1:0]        qtime_i,
  input  wire logic [KW-1:0]            num_i,
  input  wire logic                     cnt_we_i,
  input  wire logic [LW-1:0]            cnt_link_i,
  input  wire logic [CW-1:0]            cnt_val_i,
  // Memory read port.
  output logic                          rd_en_o,
  output logic      [AW-1:0]            rd_addr_o,
  input  wire logic [TIME_W+DIS_W-1:0]  rd_data_i,
  // Result hand-off.
  output logic                          busy_o,
  output logic                          res_valid_o,
  output res_t                          res_o,
  input  wire logic                     res_ready_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [TIME_W-1:0] t_q, t_d;
  logic [KW-1:0]     n_q, n_d;
  logic [KW-1:0]     k_q, k_d;
  logic [TOL_W-1:0]  tol_q, tol_d;
  logic [TIME_W-1:0] low_q, low_d;
  logic [TIME_W:0]   high_q, high_d;
  logic [CW-1:0]     cnt_sel_q, cnt_sel_d;
  logic [CW-1:0]     cnt_m1_q, cnt_m1_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hi_q, hi_d;
  logic [CW-1:0]     i_q, i_d;
  logic [DIS_W-1:0]  res_dis_q, res_dis_d;
  status_e           res_st_q, res_st_d;

  logic [CW-1:0]     cnt_mem_q [NUM_LINKS];

  logic [LW-1:0]     k_link;
  logic [CW-1:0]     cur_cnt;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] ti;
  logic [DIS_W-1:0]  td;
  logic [CW:0]       ip1, sum_a, sum_b;
  logic [CW-1:0]     i_a, i_b, i_new, i_clamp;
  logic              done_a, done_b, done, hit, below, res_last;
  logic [CW-1:0]     rd_step;

  assign k_link  = LW'(k_q);
  assign cur_cnt = cnt_mem_q[k_link];
  assign prod    = PROD_W'(t_q) * PROD_W'(TOL_MUL);
  assign ti      = rd_data_i[TIME_W-1:0];
  assign td      = rd_data_i[TIME_W+DIS_W-1:TIME_W];

  // Both successors of the interval are prepared; the compare only selects one.
  assign ip1    = {1'b0, i_q} + {{CW{1'b0}}, 1'b1};
  assign sum_a  = ip1 + {1'b0, hi_q};
  assign i_a    = sum_a[CW:1];
  assign done_a = ip1 >= {1'b0, hi_q};
  assign sum_b  = {1'b0, lo_q} + {1'b0, i_q};
  assign i_b    = sum_b[CW:1];
  assign done_b = lo_q >= i_q;

  assign hit     = (ti >= low_q) && ({1'b0, ti} <= high_q);
  assign below   = ti < t_q;
  assign i_new   = below ? i_a : i_b;
  assign done    = below ? done_a : done_b;
  assign i_clamp = (i_new > cnt_m1_q) ? cnt_m1_q : i_new;

  assign res_last = (k_q + {{(KW-1){1'b0}}, 1'b1}) == n_q;

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    n_d         = n_q;
    k_d         = k_q;
    tol_d       = tol_q;
    low_d       = low_q;
    high_d      = high_q;
    cnt_sel_d   = cnt_sel_q;
    cnt_m1_d    = cnt_m1_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    res_dis_d   = res_dis_q;
    res_st_d    = res_st_q;
    rd_en_o     = 1'b0;
    rd_step     = '0;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          t_d     = qtime_i;
          n_d     = num_i;
          k_d     = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        tol_d   = prod[PROD_W-1:TOL_SHIFT];
        state_d = S_START;
      end
      S_START: begin
        low_d  = t_q - TIME_W'(tol_q);
        high_d = {1'b0, t_q} + (TIME_W + 1)'(tol_q);
        if (cur_cnt == '0) begin
          res_dis_d = '0;
          res_st_d  = ST_EMPTY;
          state_d   = S_EMIT;
        end else begin
          rd_en_o   = 1'b1;
          rd_step   = cur_cnt - {{(CW-1){1'b0}}, 1'b1};
          cnt_sel_d = cur_cnt;
          cnt_m1_d  = cur_cnt - {{(CW-1){1'b0}}, 1'b1};
          state_d   = S_LAST;
        end
      end
      S_LAST: begin
        if (t_q > ti) begin
          res_dis_d = td;
          res_st_d  = ST_CLAMP;
          state_d   = S_EMIT;
        end else begin
          lo_d    = '0;
          hi_d    = cnt_sel_q;
          i_d     = cnt_sel_q >> 1;
          rd_en_o = 1'b1;
          rd_step = cnt_sel_q >> 1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          res_dis_d = td;
          res_st_d  = ST_MATCH;
          state_d   = S_EMIT;
        end else begin
          lo_d    = below ? ip1[CW-1:0] : lo_q;
          hi_d    = below ? hi_q : i_q;
          i_d     = i_new;
          rd_en_o = 1'b1;
          if (done) begin
            rd_step = i_clamp;
            state_d = S_FETCH;
          end else begin
            rd_step = i_new;
          end
        end
      end
      S_FETCH: begin
        res_dis_d = td;
        res_st_d  = ST_NOT_FOUND;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (res_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + {{(KW-1){1'b0}}, 1'b1};
            state_d = S_START;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_addr_o = {k_link, rd_step[SW-1:0]};
  assign busy_o    = state_q != S_IDLE;

  assign res_o.link      = LINK_W'(k_q);
  assign res_o.discharge = res_dis_q;
  assign res_o.status    = res_st_q;
  assign res_o.last      = res_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      k_q     <= '0;
      for (int j = 0; j < NUM_LINKS; j++) begin
        cnt_mem_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
      if (cnt_we_i) begin
        cnt_mem_q[cnt_link_i] <= cnt_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    tol_q     <= tol_d;
    low_q     <= low_d;
    high_q    <= high_d;
    cnt_sel_q <= cnt_sel_d;
    cnt_m1_q  <= cnt_m1_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    i_q       <= i_d;
    res_dis_q <= res_dis_d;
    res_st_q  <= res_st_d;
  end

endmodule

`default_nettype wire

>>> tb/tb_per_link_time_table_search.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_per_link_time_table_search
// Self-checking bench for the per-link time table search. Link tables and
// entry counts are loaded over the input stream and queries are sent between
// the loads. The bench keeps its own copy of the tables, runs the tolerant
// binary search for every active link and checks each result transaction
// against the oldest expected one. Both stream sides idle at random, and one
// long receiver hold-off backs the block up into its input.
// ---------------------------------------------------------------------------
module tb_per_link_time_table_search;
  import pltts_pkg::*;

  localparam int LINKS         = NUM_LINKS_DEF;
  localparam int STEPS         = MAX_STEPS_DEF;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int STALL_LIMIT   = 20000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [LINK_W-1:0]   link;
    logic [STEP_W-1:0]   step;
    logic [TIME_W-1:0]   etime;
    logic [DIS_W-1:0]    edis;
    logic [ECOUNT_W-1:0] ecount;
    logic [TIME_W-1:0]   qtime;
  } table_cmd_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [S_TUSER_W-1:0] s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tlast;

  // Shadow copy of the block's tables and register.
  logic [TIME_W-1:0] tbl_time    [LINKS][STEPS];
  logic [DIS_W-1:0]  tbl_dis     [LINKS][STEPS];
  bit                tbl_written [LINKS][STEPS];
  int unsigned       tbl_count   [LINKS] = '{default: 0};
  int unsigned       active_cfg  = 1;
  res_t              pending_q[$];

  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_token   = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;

  always #4 clk = ~clk;

  per_link_time_table_search dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
  endfunction

  function automatic logic [63:0] tolerance(input logic [TIME_W-1:0] t);
    logic [63:0] prod;
    prod = {32'd0, t} * {50'd0, TOL_MUL};
    return prod >> TOL_SHIFT;
  endfunction

  function automatic void search_link(input int unsigned lk, input logic [TIME_W-1:0] t,
                                      output logic [DIS_W-1:0] dis, output status_e stat);
    int unsigned cnt, lo, hi, idx;
    logic [63:0] tol, lo_b, hi_b, ti;
    cnt  = tbl_count[lk];
    dis  = '0;
    stat = ST_EMPTY;
    if (cnt == 0) return;
    if (t > tbl_time[lk][cnt-1]) begin
      dis  = tbl_dis[lk][cnt-1];
      stat = ST_CLAMP;
      return;
    end
    tol  = tolerance(t);
    lo_b = {32'd0, t} - tol;
    hi_b = {32'd0, t} + tol;
    lo   = 0;
    hi   = cnt;
    idx  = cnt / 2;
    while (lo < hi) begin
      ti = {32'd0, tbl_time[lk][idx]};
      if (ti >= lo_b && ti <= hi_b) begin
        dis  = tbl_dis[lk][idx];
        stat = ST_MATCH;
        return;
      end
      if (ti < {32'd0, t}) lo = idx + 1;
      else hi = idx;
      idx = (lo + hi) / 2;
    end
    if (idx > cnt - 1) idx = cnt - 1;
    dis  = tbl_dis[lk][idx];
    stat = ST_NOT_FOUND;
  endfunction

  // Applies one accepted transaction to the shadow state and queues its results.
  function automatic void predict(input table_cmd_t it);
    int unsigned n, k;
    res_t r;
    logic [DIS_W-1:0] dis;
    status_e stat;
    case (it.cmd)
      CMD_LOAD: begin
        tbl_time[it.link][it.step]    = it.etime;
        tbl_dis[it.link][it.step]     = it.edis;
        tbl_written[it.link][it.step] = 1'b1;
      end
      CMD_COUNT: tbl_count[it.link] = (it.ecount > STEPS) ? STEPS : it.ecount;
      CMD_QUERY: begin
        n = (active_cfg > LINKS) ? LINKS : active_cfg;
        if (n > RES_CAP) n = RES_CAP;
        for (k = 0; k < n; k++) begin
          search_link(k, it.qtime, dis, stat);
          r.link      = k[LINK_W-1:0];
          r.discharge = dis;
          r.status    = stat;
          r.last      = (k + 1 == n);
          pending_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned written_prefix(input int unsigned lk);
    int unsigned n;
    n = 0;
    while (n < STEPS && tbl_written[lk][n]) n++;
    return n;
  endfunction

  // Unused fields carry random filler; the block must ignore them.
  function automatic table_cmd_t make_item(input logic [CMD_W-1:0] code);
    table_cmd_t it;
    it.cmd    = code;
    it.link   = LINK_W'($urandom);
    it.step   = STEP_W'($urandom);
    it.etime  = $urandom;
    it.edis   = $urandom;
    it.ecount = ECOUNT_W'($urandom);
    it.qtime  = $urandom;
    return it;
  endfunction

  // Picks a query time near a stored entry most of the time, so that the
  // search reaches matches, misses just outside the tolerance, and clamps.
  function automatic logic [TIME_W-1:0] pick_query_time();
    int unsigned n, k, cnt, idx, pick, tries, tolu;
    logic [63:0] t;
    n     = (active_cfg > LINKS) ? LINKS : active_cfg;
    pick  = $urandom_range(0, 99);
    cnt   = 0;
    k     = 0;
    tries = 0;
    while (n > 0 && cnt == 0 && tries < 8) begin
      k   = $urandom_range(0, n - 1);
      cnt = tbl_count[k];
      tries++;
    end
    if (cnt == 0 || pick >= 90) return $urandom;
    idx  = $urandom_range(0, cnt - 1);
    t    = {32'd0, tbl_time[k][idx]};
    tolu = 32'(tolerance(t[31:0]));
    if (pick < 35) ;
    else if (pick < 50) t = t + $urandom_range(0, tolu);
    else if (pick < 62) t = (t > tolu) ? t - $urandom_range(0, tolu) : t;
    else if (pick < 74) t = t + tolu + 1 + $urandom_range(0, 3 * tolu + 5);
    else if (pick < 82) t = {32'd0, tbl_time[k][cnt-1]} + $urandom_range(1, 1000);
    else if (pick < 86) t = 64'd0;
    else t = 64'hFFFF_FFFF;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    return t[31:0];
  endfunction

  task automatic send_item(input table_cmd_t it);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {7'd0, it.qtime, it.ecount, it.edis, it.etime, it.step, it.link};
    do @(posedge clk); while (!s_tready);
    predict(it);
    items_sent++;
  endtask

  task automatic send_load(input int unsigned lk, input int unsigned s,
                           input logic [TIME_W-1:0] t, input logic [DIS_W-1:0] d);
    table_cmd_t it;
    it       = make_item(CMD_LOAD);
    it.link  = LINK_W'(lk);
    it.step  = STEP_W'(s);
    it.etime = t;
    it.edis  = d;
    send_item(it);
  endtask

  task automatic send_count(input int unsigned lk, input int unsigned c);
    table_cmd_t it;
    it        = make_item(CMD_COUNT);
    it.link   = LINK_W'(lk);
    it.ecount = ECOUNT_W'(c);
    send_item(it);
  endtask

  task automatic send_query(input logic [TIME_W-1:0] t);
    table_cmd_t it;
    it       = make_item(CMD_QUERY);
    it.qtime = t;
    send_item(it);
  endtask

  // Loads a sorted table of n entries starting at step 0, then sets the count.
  task automatic load_table(input int unsigned lk, input int unsigned n,
                            input logic [TIME_W-1:0] base, input int unsigned gap_max);
    logic [63:0] t;
    int unsigned s;
    t = {32'd0, base} + $urandom_range(0, gap_max);
    for (s = 0; s < n; s++) begin
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      send_load(lk, s, t[31:0], $urandom);
      t = t + $urandom_range(0, gap_max);
    end
    send_count(lk, n);
  endtask

  task automatic release_stream();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Loads give no result, so a settle pause follows the last expected result.
  task automatic wait_idle();
    release_stream();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_links(input int unsigned v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    active_cfg = v[CFG_W-1:0];
  endtask

  task automatic test_reset_state();
    send_query($urandom);
    write_active_links(0);
    send_query($urandom);
    write_active_links(31);
    send_query($urandom);
  endtask

  task automatic test_directed_search();
    send_load(0, 0, 32'd1_000_000, 32'hFFFF_FFFF);
    send_load(0, 1, 32'd2_000_000, 32'h0000_0000);
    send_load(0, 2, 32'd3_000_000, 32'h1234_5678);
    send_load(0, 3, 32'd4_000_000, 32'h8000_0000);
    send_count(0, 4);
    // Link 1 is deliberately unsorted so that the search can close without a match.
    send_load(1, 0, 32'd500, 32'h0001_0000);
    send_load(1, 1, 32'd0, 32'h0002_0000);
    send_load(1, 2, 32'hFFFF_FFFF, 32'h0003_0000);
    send_count(1, 3);
    send_count(2, 0);
    write_active_links(3);
    send_query(32'd3_000_000);
    send_query(32'd3_000_029);
    send_query(32'd3_000_031);
    send_query(32'd2_500_000);
    send_query(32'd5_000_000);
    send_query(32'd0);
    send_query(32'hFFFF_FFFF);
    send_query(32'd100);
    send_item(make_item(CMD_RESERVED));
  endtask

  task automatic test_full_table();
    int unsigned q;
    load_table(15, 32, 32'd1_000_000, 50_000);
    write_active_links(16);
    for (q = 0; q < 10; q++) send_query(pick_query_time());
    send_query(32'd0);
    send_query(32'hFFFF_FFFF);
  endtask

  task automatic test_random_phase(input int unsigned active_v, input int unsigned n_items);
    int unsigned stop_at, pick, lk, span, gap_max;
    logic [TIME_W-1:0] base;
    write_active_links(active_v);
    span    = (active_v == 0) ? 1 : ((active_v > LINKS) ? LINKS : active_v);
    stop_at = items_sent + n_items;
    base    = $urandom_range(32'h0001_0000, 32'hF000_0000);
    case ($urandom_range(0, 3))
      0: gap_max = 3;
      1: gap_max = base >> 16;
      2: gap_max = base >> 12;
      default: gap_max = base >> 8;
    endcase
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      lk   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
                                         : $urandom_range(0, LINKS - 1);
      if (pick < 20) load_table(lk, $urandom_range(1, 12), base, gap_max);
      else if (pick < 75) send_query(pick_query_time());
      else if (pick < 85) send_count(lk, $urandom_range(0, written_prefix(lk)));
      else if (pick < 94)
        send_load(lk, $urandom_range(0, STEPS - 1),
                  $urandom_range(0, 1) ? base + $urandom_range(0, 20 * gap_max) : $urandom,
                  $urandom);
      else send_item(make_item(CMD_RESERVED));
    end
  endtask

  task automatic test_random_tables();
    test_random_phase($urandom_range(1, 16), 50);
    test_random_phase(16, 50);
    test_random_phase(1, 40);
    test_random_phase($urandom_range(0, 31), 40);
    test_random_phase($urandom_range(2, 15), 50);
  endtask

  task automatic test_backpressure();
    int unsigned q;
    write_active_links(16);
    hold_token <= hold_token + 1;
    for (q = 0; q < 6; q++) send_query(pick_query_time());
  endtask

  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_phase($urandom_range(4, 16), 30);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned seen_hold;
    seen_hold = 0;
    forever begin
      @(posedge clk);
      if (hold_token != seen_hold) begin
        seen_hold = hold_token;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got.link      = m_tdata[3:0];
      got.discharge = m_tdata[35:4];
      got.status    = status_e'(m_tuser);
      got.last      = m_tlast;
      if (pending_q.size() == 0) begin
        note_error($sformatf("unexpected result: link %0d dis %h status %0d last %b",
                             got.link, got.discharge, got.status, got.last));
      end else begin
        want = pending_q.pop_front();
        if (got.link !== want.link || got.discharge !== want.discharge ||
            got.status !== want.status || got.last !== want.last)
          note_error($sformatf({"expected link %0d dis %h status %0d last %b, ",
                                "got link %0d dis %h status %0d last %b"},
                               want.link, want.discharge, want.status, want.last,
                               got.link, got.discharge, got.status, got.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_search();
    test_full_table();
    test_random_tables();
    test_backpressure();
    test_steady_stream();
    release_stream();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/pltts_pkg.sv
src/pltts_table_mem.sv
src/pltts_search_core.sv
src/per_link_time_table_search.sv
tb/tb_per_link_time_table_search.sv
